// ----- rtl/rhpt_pkg.sv -----
// Shared constants, types and helpers for the Robin Hood pointer table.
`timescale 1ns / 1ps
`default_nettype none

package rhpt_pkg;

    localparam int SLOTS      = 1024;
    localparam int IDX_W      = $clog2(SLOTS);
    localparam int HOME_W     = IDX_W + 1;
    localparam int CNT_W      = IDX_W + 1;
    localparam int KEY_W      = 48;
    localparam int HASH_SHIFT = 3;
    localparam int KIND_W     = 3;
    localparam int SIZE_W     = 32;
    localparam int HDL_W      = 64;
    localparam int TOT_W      = 64;
    localparam int STATUS_W   = 2;

    // Input word layout, lowest bit first.
    localparam int IN_KIND_LO = 0;
    localparam int IN_KEY_LO  = IN_KIND_LO + KIND_W;
    localparam int IN_SIZE_LO = IN_KEY_LO + KEY_W;
    localparam int IN_DTOR_LO = IN_SIZE_LO + SIZE_W;
    localparam int IN_MRK_LO  = IN_DTOR_LO + HDL_W;
    localparam int IN_BITS    = IN_MRK_LO + HDL_W;
    localparam int IN_W       = ((IN_BITS + 7) / 8) * 8;

    // Output word layout, lowest bit first.
    localparam int OUT_STATUS_LO = 0;
    localparam int OUT_SIZE_LO   = OUT_STATUS_LO + STATUS_W;
    localparam int OUT_DTOR_LO   = OUT_SIZE_LO + SIZE_W;
    localparam int OUT_MRK_LO    = OUT_DTOR_LO + HDL_W;
    localparam int OUT_ROOT_LO   = OUT_MRK_LO + HDL_W;
    localparam int OUT_OCC_LO    = OUT_ROOT_LO + 1;
    localparam int OUT_TOT_LO    = OUT_OCC_LO + CNT_W;
    localparam int OUT_BITS      = OUT_TOT_LO + TOT_W;
    localparam int OUT_W         = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 3'd0,
        KIND_LOOKUP = 3'd1,
        KIND_REMOVE = 3'd2,
        KIND_UPDATE = 3'd3,
        KIND_ROOT   = 3'd4
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 2'd0,
        ST_PRESENT  = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [SIZE_W-1:0] size;
        logic [HDL_W-1:0]  dtor;
        logic [HDL_W-1:0]  marker;
        logic              root;
    } entry_t;

    // Controller to datapath.
    typedef struct packed {
        logic    accept;
        logic    find;
        logic    ins_start;
        logic    ins_walk;
        logic    shift;
        logic    modify;
        logic    clear;
        logic    out_load;
        status_t status;
        logic    report;
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              hit;
        logic              miss;
        logic              empty;
        logic              shift_stop;
        logic              full;
        logic              clr_last;
        logic              out_busy;
    } sts_t;

    function automatic logic [IDX_W-1:0] home_of(input logic [KEY_W-1:0] key);
        return key[HASH_SHIFT +: IDX_W];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/robin_hood_pointer_table_core.sv -----
// Top level of the Robin Hood pointer table: controller and datapath.
`timescale 1ns / 1ps
`default_nettype none

// Open-addressed Robin Hood table of 1024 slots keyed by block address, home slot
// (key >> 3) mod 1024. After reset the block clears the slot-home memory with
// s_tready low. One word is processed at a time; probed and shifted slots are read
// one after another through the registered-read slot memory. A lookup probes from
// the home slot; update and set root probe, then write the changed entry back;
// insert probes, then walks from home up to and including the free slot; remove
// probes, then shifts the followers back. Each item ends by loading the result. The
// result load waits while the previous result is still stalled at the output. A result
// waits in the output register while the next word is accepted.
module robin_hood_pointer_table_core (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        s_tvalid,
    output logic                       s_tready,
    // kind[2:0], key[50:3], entry_size[82:51], dtor_handle[146:83],
    // marker_handle[210:147], zero fill up to bit 215
    input  wire [rhpt_pkg::IN_W-1:0]   s_tdata,
    output logic                       m_tvalid,
    input  wire                        m_tready,
    // status[1:0], found_size[33:2], found_dtor[97:34], found_marker[161:98],
    // found_root[162], occupancy[173:163], allocated_total[237:174], zero fill
    output logic [rhpt_pkg::OUT_W-1:0] m_tdata
);

    rhpt_pkg::cmd_t cmd;
    rhpt_pkg::sts_t sts;

    rhpt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rhpt_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

endmodule

`default_nettype wire

// ----- rtl/rhpt_datapath.sv -----
// Datapath of the pointer table: slot memories, probe registers, totals and result register.
`timescale 1ns / 1ps
`default_nettype none

module rhpt_datapath (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire rhpt_pkg::cmd_t        cmd,
    output rhpt_pkg::sts_t             sts,
    input  wire [rhpt_pkg::IN_W-1:0]   s_tdata,
    output logic [rhpt_pkg::OUT_W-1:0] m_tdata,
    output logic                       m_tvalid,
    input  wire                        m_tready
);

    // Slot memories.
    logic [rhpt_pkg::HOME_W-1:0] home_mem [rhpt_pkg::SLOTS];
    rhpt_pkg::entry_t            entry_mem [rhpt_pkg::SLOTS];

    logic [rhpt_pkg::HOME_W-1:0] rd_home_reg;
    rhpt_pkg::entry_t            rd_entry_reg;
    logic [rhpt_pkg::IDX_W-1:0]  rd_addr;

    logic                        wr_en;
    logic [rhpt_pkg::IDX_W-1:0]  wr_addr;
    logic [rhpt_pkg::HOME_W-1:0] wr_home;
    rhpt_pkg::entry_t            wr_entry;

    // Operation registers.
    logic [rhpt_pkg::KIND_W-1:0] kind_reg;
    logic [rhpt_pkg::KEY_W-1:0]  key_reg;
    logic [rhpt_pkg::SIZE_W-1:0] size_reg;
    logic [rhpt_pkg::HDL_W-1:0]  dtor_reg;
    logic [rhpt_pkg::HDL_W-1:0]  mrk_reg;

    logic [rhpt_pkg::IDX_W-1:0]  idx_reg;
    logic [rhpt_pkg::IDX_W:0]    j_reg;
    logic [rhpt_pkg::HOME_W-1:0] car_home_reg;
    rhpt_pkg::entry_t            car_entry_reg;
    logic [rhpt_pkg::HOME_W-1:0] found_home_reg;
    rhpt_pkg::entry_t            found_entry_reg;
    rhpt_pkg::entry_t            mod_entry;

    logic [rhpt_pkg::CNT_W-1:0]  count_reg;
    logic [rhpt_pkg::TOT_W-1:0]  total_reg;

    logic [rhpt_pkg::STATUS_W-1:0] out_status_reg;
    rhpt_pkg::entry_t              out_entry_reg;
    logic [rhpt_pkg::CNT_W-1:0]    out_occ_reg;
    logic [rhpt_pkg::TOT_W-1:0]    out_tot_reg;

    logic [rhpt_pkg::IDX_W-1:0]  slot_dist;
    logic [rhpt_pkg::IDX_W-1:0]  idx_prev;
    logic                        empty;
    logic                        swap;
    logic [rhpt_pkg::KEY_W-1:0]  in_key;

    // Probe evaluation of the slot read last cycle.
    always_comb begin
        in_key    = s_tdata[rhpt_pkg::IN_KEY_LO +: rhpt_pkg::KEY_W];
        slot_dist = idx_reg - rd_home_reg[rhpt_pkg::IDX_W-1:0] + rhpt_pkg::IDX_W'(1);
        idx_prev  = idx_reg - rhpt_pkg::IDX_W'(1);
        empty     = (rd_home_reg == '0);
        swap      = (j_reg >= {1'b0, slot_dist});
    end

    always_comb begin
        sts.kind       = kind_reg;
        sts.miss       = (j_reg == (rhpt_pkg::IDX_W+1)'(rhpt_pkg::SLOTS)) || empty
                         || (j_reg > {1'b0, slot_dist});
        sts.hit        = !sts.miss && (rd_entry_reg.key == key_reg);
        sts.empty      = empty;
        sts.shift_stop = empty || (slot_dist == '0)
                         || (j_reg == (rhpt_pkg::IDX_W+1)'(rhpt_pkg::SLOTS - 1));
        sts.full       = (count_reg >= rhpt_pkg::CNT_W'(rhpt_pkg::SLOTS));
        sts.clr_last   = (idx_reg == rhpt_pkg::IDX_W'(rhpt_pkg::SLOTS - 1));
        sts.out_busy   = m_tvalid && !m_tready;
    end

    // Found entry with the requested change applied.
    always_comb begin
        mod_entry = found_entry_reg;
        if (kind_reg == rhpt_pkg::KIND_UPDATE) begin
            mod_entry.size   = size_reg;
            mod_entry.dtor   = dtor_reg;
            mod_entry.marker = mrk_reg;
        end else begin
            mod_entry.root = 1'b1;
        end
    end

    // Read address: the home slot when a walk starts, otherwise the next slot.
    always_comb begin
        if (cmd.accept) begin
            rd_addr = rhpt_pkg::home_of(in_key);
        end else if (cmd.ins_start) begin
            rd_addr = rhpt_pkg::home_of(key_reg);
        end else begin
            rd_addr = idx_reg + rhpt_pkg::IDX_W'(1);
        end
    end

    // Write port selection.
    always_comb begin
        wr_en    = 1'b0;
        wr_addr  = idx_reg;
        wr_home  = '0;
        wr_entry = rd_entry_reg;
        if (cmd.clear) begin
            wr_en = 1'b1;
        end else if (cmd.ins_walk) begin
            wr_en    = empty || swap;
            wr_home  = car_home_reg;
            wr_entry = car_entry_reg;
        end else if (cmd.shift) begin
            wr_en   = 1'b1;
            wr_addr = idx_prev;
            wr_home = sts.shift_stop ? '0 : rd_home_reg;
        end else if (cmd.modify) begin
            wr_en    = 1'b1;
            wr_addr  = idx_prev;
            wr_home  = found_home_reg;
            wr_entry = mod_entry;
        end
    end

    // Slot memories, registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            home_mem[wr_addr]  <= wr_home;
            entry_mem[wr_addr] <= wr_entry;
        end
        rd_home_reg  <= home_mem[rd_addr];
        rd_entry_reg <= entry_mem[rd_addr];
    end

    // Probe indexes, carried item and captured operands.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
            j_reg   <= '0;
        end else if (cmd.accept) begin
            kind_reg <= s_tdata[rhpt_pkg::IN_KIND_LO +: rhpt_pkg::KIND_W];
            key_reg  <= in_key;
            size_reg <= s_tdata[rhpt_pkg::IN_SIZE_LO +: rhpt_pkg::SIZE_W];
            dtor_reg <= s_tdata[rhpt_pkg::IN_DTOR_LO +: rhpt_pkg::HDL_W];
            mrk_reg  <= s_tdata[rhpt_pkg::IN_MRK_LO +: rhpt_pkg::HDL_W];
            idx_reg  <= rhpt_pkg::home_of(in_key);
            j_reg    <= '0;
        end else if (cmd.find) begin
            idx_reg <= idx_reg + rhpt_pkg::IDX_W'(1);
            if (sts.hit) begin
                found_home_reg  <= rd_home_reg;
                found_entry_reg <= rd_entry_reg;
                j_reg           <= '0;
            end else begin
                j_reg <= j_reg + (rhpt_pkg::IDX_W+1)'(1);
            end
        end else if (cmd.ins_start) begin
            idx_reg       <= rhpt_pkg::home_of(key_reg);
            j_reg         <= '0;
            car_home_reg  <= {1'b0, rhpt_pkg::home_of(key_reg)} + rhpt_pkg::HOME_W'(1);
            car_entry_reg <= '{key: key_reg, size: size_reg, dtor: dtor_reg,
                               marker: mrk_reg, root: 1'b0};
        end else if (cmd.ins_walk) begin
            idx_reg <= idx_reg + rhpt_pkg::IDX_W'(1);
            if (!empty && swap) begin
                car_home_reg  <= rd_home_reg;
                car_entry_reg <= rd_entry_reg;
                j_reg         <= {1'b0, slot_dist} + (rhpt_pkg::IDX_W+1)'(1);
            end else begin
                j_reg <= j_reg + (rhpt_pkg::IDX_W+1)'(1);
            end
        end else if (cmd.shift || cmd.clear) begin
            idx_reg <= idx_reg + rhpt_pkg::IDX_W'(1);
            j_reg   <= j_reg + (rhpt_pkg::IDX_W+1)'(1);
        end else if (cmd.modify) begin
            found_entry_reg <= mod_entry;
        end
    end

    // Entry count and byte total.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            total_reg <= '0;
        end else if (cmd.find && sts.hit && kind_reg == rhpt_pkg::KIND_REMOVE) begin
            count_reg <= count_reg - rhpt_pkg::CNT_W'(1);
            total_reg <= total_reg - rhpt_pkg::TOT_W'(rd_entry_reg.size);
        end else if (cmd.ins_walk && empty) begin
            count_reg <= count_reg + rhpt_pkg::CNT_W'(1);
            total_reg <= total_reg + rhpt_pkg::TOT_W'(size_reg);
        end else if (cmd.modify && kind_reg == rhpt_pkg::KIND_UPDATE) begin
            total_reg <= total_reg - rhpt_pkg::TOT_W'(found_entry_reg.size)
                         + rhpt_pkg::TOT_W'(size_reg);
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid <= 1'b1;
        end else if (m_tready) begin
            m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_status_reg <= cmd.status;
            out_entry_reg  <= cmd.report ? found_entry_reg : '0;
            out_occ_reg    <= count_reg;
            out_tot_reg    <= total_reg;
        end
    end

    always_comb begin
        m_tdata = '0;
        m_tdata[rhpt_pkg::OUT_STATUS_LO +: rhpt_pkg::STATUS_W] = out_status_reg;
        m_tdata[rhpt_pkg::OUT_SIZE_LO +: rhpt_pkg::SIZE_W]     = out_entry_reg.size;
        m_tdata[rhpt_pkg::OUT_DTOR_LO +: rhpt_pkg::HDL_W]      = out_entry_reg.dtor;
        m_tdata[rhpt_pkg::OUT_MRK_LO +: rhpt_pkg::HDL_W]       = out_entry_reg.marker;
        m_tdata[rhpt_pkg::OUT_ROOT_LO]                         = out_entry_reg.root;
        m_tdata[rhpt_pkg::OUT_OCC_LO +: rhpt_pkg::CNT_W]       = out_occ_reg;
        m_tdata[rhpt_pkg::OUT_TOT_LO +: rhpt_pkg::TOT_W]       = out_tot_reg;
    end

endmodule

`default_nettype wire

// ----- rtl/rhpt_ctrl.sv -----
// Controller state machine of the pointer table.
`timescale 1ns / 1ps
`default_nettype none

module rhpt_ctrl (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  wire rhpt_pkg::sts_t sts,
    output rhpt_pkg::cmd_t      cmd
);

    typedef enum logic [7:0] {
        S_CLEAR     = 8'b0000_0001,
        S_IDLE      = 8'b0000_0010,
        S_FIND      = 8'b0000_0100,
        S_INS_START = 8'b0000_1000,
        S_INS_WALK  = 8'b0001_0000,
        S_SHIFT     = 8'b0010_0000,
        S_MODIFY    = 8'b0100_0000,
        S_DONE      = 8'b1000_0000
    } state_t;

    state_t            state_reg, state_next;
    rhpt_pkg::status_t status_reg, status_next;
    logic              rep_reg, rep_next;

    always_comb begin
        s_tready = (state_reg == S_IDLE);
    end

    // Next state and commands.
    always_comb begin
        state_next  = state_reg;
        status_next = status_reg;
        rep_next    = rep_reg;
        cmd         = '0;
        cmd.status  = status_reg;
        cmd.report  = rep_reg;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clear = 1'b1;
                if (sts.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = S_FIND;
                end
            end
            S_FIND: begin
                cmd.find = 1'b1;
                if (sts.kind > rhpt_pkg::KIND_ROOT) begin
                    status_next = rhpt_pkg::ST_NOTFOUND;
                    rep_next    = 1'b0;
                    state_next  = S_DONE;
                end else if (sts.hit) begin
                    status_next = rhpt_pkg::ST_DONE;
                    rep_next    = 1'b1;
                    unique case (sts.kind)
                        rhpt_pkg::KIND_INSERT: begin
                            status_next = rhpt_pkg::ST_PRESENT;
                            state_next  = S_DONE;
                        end
                        rhpt_pkg::KIND_LOOKUP: state_next = S_DONE;
                        rhpt_pkg::KIND_REMOVE: state_next = S_SHIFT;
                        default:               state_next = S_MODIFY;
                    endcase
                end else if (sts.miss) begin
                    rep_next = 1'b0;
                    if (sts.kind != rhpt_pkg::KIND_INSERT) begin
                        status_next = rhpt_pkg::ST_NOTFOUND;
                        state_next  = S_DONE;
                    end else if (sts.full) begin
                        status_next = rhpt_pkg::ST_FULL;
                        state_next  = S_DONE;
                    end else begin
                        status_next = rhpt_pkg::ST_DONE;
                        state_next  = S_INS_START;
                    end
                end
            end
            S_INS_START: begin
                cmd.ins_start = 1'b1;
                state_next    = S_INS_WALK;
            end
            S_INS_WALK: begin
                cmd.ins_walk = 1'b1;
                if (sts.empty) begin
                    state_next = S_DONE;
                end
            end
            S_SHIFT: begin
                cmd.shift = 1'b1;
                if (sts.shift_stop) begin
                    state_next = S_DONE;
                end
            end
            S_MODIFY: begin
                cmd.modify = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!sts.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_CLEAR;
            status_reg <= rhpt_pkg::ST_DONE;
            rep_reg    <= 1'b0;
        end else begin
            state_reg  <= state_next;
            status_reg <= status_next;
            rep_reg    <= rep_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/rhpt_checker.sv -----
// Port-level checks of the pointer table and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none

module rhpt_checker (
    input wire                        aclk,
    input wire                        aresetn,
    input wire                        s_tvalid,
    input wire                        s_tready,
    input wire                        m_tvalid,
    input wire                        m_tready,
    input wire [rhpt_pkg::OUT_W-1:0]  m_tdata
);

    logic [rhpt_pkg::STATUS_W-1:0] st;
    logic [rhpt_pkg::CNT_W-1:0]    occ;

    assign st  = m_tdata[rhpt_pkg::OUT_STATUS_LO +: rhpt_pkg::STATUS_W];
    assign occ = m_tdata[rhpt_pkg::OUT_OCC_LO +: rhpt_pkg::CNT_W];

    // A stalled result word stays offered.
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    // A stalled result word keeps its contents.
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result word changed while stalled");

    // Only one word is taken at a time.
    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again while a word is in flight");

    // A full status is only given when every slot is taken.
    a_full_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && st == rhpt_pkg::ST_FULL |-> occ == rhpt_pkg::CNT_W'(rhpt_pkg::SLOTS))
        else $error("table full reported below capacity");

    // A not-found result carries no entry contents.
    a_nf_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && st == rhpt_pkg::ST_NOTFOUND
        |-> m_tdata[rhpt_pkg::OUT_ROOT_LO:rhpt_pkg::OUT_SIZE_LO] == '0)
        else $error("entry fields set on a not-found result");

endmodule

bind robin_hood_pointer_table_core rhpt_checker u_rhpt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ----- tb/rhpt_checker.sv -----
// Checker for the Robin Hood pointer table: predicts every result word and compares it.
`timescale 1ns / 1ps

module rhpt_scoreboard
    import rhpt_pkg::*;
(
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              s_tvalid,
    input  wire              s_tready,
    input  wire [IN_W-1:0]   s_tdata,
    input  wire              m_tvalid,
    input  wire              m_tready,
    input  wire [OUT_W-1:0]  m_tdata,
    output int               fail_count,
    output int               pending
);

    typedef struct {
        status_t           status;
        logic [SIZE_W-1:0] size;
        logic [HDL_W-1:0]  dtor;
        logic [HDL_W-1:0]  marker;
        logic              root;
        logic [CNT_W-1:0]  occupancy;
        logic [TOT_W-1:0]  total;
    } table_reply_t;

    // Shadow copy of the table contents.
    int unsigned       shadow_home [SLOTS];
    logic [KEY_W-1:0]  shadow_key [SLOTS];
    logic [SIZE_W-1:0] shadow_size [SLOTS];
    logic [HDL_W-1:0]  shadow_dtor [SLOTS];
    logic [HDL_W-1:0]  shadow_marker [SLOTS];
    logic              shadow_root [SLOTS];
    int unsigned       shadow_count;
    logic [TOT_W-1:0]  shadow_bytes;

    table_reply_t replies_due[$];

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            shadow_home[i] = 0;
            shadow_key[i] = '0;
            shadow_size[i] = '0;
            shadow_dtor[i] = '0;
            shadow_marker[i] = '0;
            shadow_root[i] = 1'b0;
        end
        shadow_count = 0;
        shadow_bytes = '0;
        fail_count = 0;
    end

    function automatic int unsigned home_slot(input logic [KEY_W-1:0] k);
        return int'((k >> HASH_SHIFT) % SLOTS);
    endfunction

    // Distance of the resident at slot i from its home; h holds home plus one.
    function automatic int unsigned probe_dist(input int unsigned i, input int unsigned h);
        return (i + SLOTS - (h - 1)) % SLOTS;
    endfunction

    function automatic int locate(input logic [KEY_W-1:0] k);
        int unsigned i;
        int unsigned h;
        i = home_slot(k);
        for (int unsigned j = 0; j < SLOTS; j++) begin
            h = shadow_home[i];
            if (h == 0 || j > probe_dist(i, h))
                return -1;
            if (shadow_key[i] == k)
                return int'(i);
            i = (i + 1) % SLOTS;
        end
        return -1;
    endfunction

    // Walk from home, displacing any resident no farther from home than the carried entry.
    function automatic void place_entry(input logic [KEY_W-1:0] k, input logic [SIZE_W-1:0] sz,
                                        input logic [HDL_W-1:0] dt, input logic [HDL_W-1:0] mk);
        int unsigned i, j, p, c_home, t_home;
        logic [KEY_W-1:0] c_key, t_key;
        logic [SIZE_W-1:0] c_size, t_size;
        logic [HDL_W-1:0] c_dtor, c_mrk, t_dtor, t_mrk;
        logic c_root, t_root;
        i = home_slot(k);
        c_home = i + 1; c_key = k; c_size = sz; c_dtor = dt; c_mrk = mk; c_root = 1'b0;
        j = 0;
        for (int n = 0; n < SLOTS; n++) begin
            if (shadow_home[i] == 0) begin
                shadow_home[i] = c_home; shadow_key[i] = c_key; shadow_size[i] = c_size;
                shadow_dtor[i] = c_dtor; shadow_marker[i] = c_mrk; shadow_root[i] = c_root;
                return;
            end
            p = probe_dist(i, shadow_home[i]);
            if (j >= p) begin
                t_home = shadow_home[i]; t_key = shadow_key[i]; t_size = shadow_size[i];
                t_dtor = shadow_dtor[i]; t_mrk = shadow_marker[i]; t_root = shadow_root[i];
                shadow_home[i] = c_home; shadow_key[i] = c_key; shadow_size[i] = c_size;
                shadow_dtor[i] = c_dtor; shadow_marker[i] = c_mrk; shadow_root[i] = c_root;
                c_home = t_home; c_key = t_key; c_size = t_size;
                c_dtor = t_dtor; c_mrk = t_mrk; c_root = t_root;
                j = p;
            end
            i = (i + 1) % SLOTS;
            j++;
        end
    endfunction

    // Backward shift: pull followers down until an empty slot or one at its home.
    function automatic void evict(input int unsigned s);
        int unsigned j, nj;
        j = s;
        shadow_home[s] = 0;
        for (int n = 0; n + 1 < SLOTS; n++) begin
            nj = (j + 1) % SLOTS;
            if (shadow_home[nj] == 0 || probe_dist(nj, shadow_home[nj]) == 0)
                break;
            shadow_home[j] = shadow_home[nj]; shadow_key[j] = shadow_key[nj];
            shadow_size[j] = shadow_size[nj]; shadow_dtor[j] = shadow_dtor[nj];
            shadow_marker[j] = shadow_marker[nj]; shadow_root[j] = shadow_root[nj];
            shadow_home[nj] = 0;
            j = nj;
        end
    endfunction

    function automatic table_reply_t apply_request(input logic [IN_W-1:0] w);
        table_reply_t r;
        logic [KIND_W-1:0] op;
        logic [KEY_W-1:0] k;
        logic [SIZE_W-1:0] sz;
        logic [HDL_W-1:0] dt, mk;
        int s;
        op = w[IN_KIND_LO +: KIND_W];
        k  = w[IN_KEY_LO +: KEY_W];
        sz = w[IN_SIZE_LO +: SIZE_W];
        dt = w[IN_DTOR_LO +: HDL_W];
        mk = w[IN_MRK_LO +: HDL_W];
        r.status = ST_NOTFOUND;
        r.size = '0; r.dtor = '0; r.marker = '0; r.root = 1'b0;
        s = (op <= KIND_ROOT) ? locate(k) : -1;
        if (op == KIND_INSERT) begin
            if (s >= 0) begin
                r.status = ST_PRESENT;
                r.size = shadow_size[s]; r.dtor = shadow_dtor[s];
                r.marker = shadow_marker[s]; r.root = shadow_root[s];
            end else if (shadow_count >= SLOTS) begin
                r.status = ST_FULL;
            end else begin
                place_entry(k, sz, dt, mk);
                shadow_count++;
                shadow_bytes += sz;
                r.status = ST_DONE;
            end
        end else if (op <= KIND_ROOT && s >= 0) begin
            r.status = ST_DONE;
            if (op == KIND_UPDATE) begin
                shadow_bytes = shadow_bytes - shadow_size[s] + sz;
                shadow_size[s] = sz; shadow_dtor[s] = dt; shadow_marker[s] = mk;
            end else if (op == KIND_ROOT) begin
                shadow_root[s] = 1'b1;
            end
            r.size = shadow_size[s]; r.dtor = shadow_dtor[s];
            r.marker = shadow_marker[s]; r.root = shadow_root[s];
            if (op == KIND_REMOVE) begin
                shadow_bytes -= shadow_size[s];
                evict(s);
                if (shadow_count > 0)
                    shadow_count--;
            end
        end
        r.occupancy = shadow_count[CNT_W-1:0];
        r.total = shadow_bytes;
        return r;
    endfunction

    assign pending = replies_due.size();

    // Predict on every accepted request word and compare every accepted result word.
    always @(posedge aclk) begin
        table_reply_t e;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                replies_due.push_back(apply_request(s_tdata));
            if (m_tvalid && m_tready) begin
                if (replies_due.size() == 0) begin
                    $error("result word with no request outstanding");
                    fail_count++;
                end else begin
                    e = replies_due.pop_front();
                    if (m_tdata[OUT_STATUS_LO +: STATUS_W] != e.status) begin
                        $error("status: expected %0d, got %0d", e.status,
                               m_tdata[OUT_STATUS_LO +: STATUS_W]);
                        fail_count++;
                    end
                    if (m_tdata[OUT_SIZE_LO +: SIZE_W] != e.size) begin
                        $error("found_size: expected %0h, got %0h", e.size,
                               m_tdata[OUT_SIZE_LO +: SIZE_W]);
                        fail_count++;
                    end
                    if (m_tdata[OUT_DTOR_LO +: HDL_W] != e.dtor) begin
                        $error("found_dtor: expected %0h, got %0h", e.dtor,
                               m_tdata[OUT_DTOR_LO +: HDL_W]);
                        fail_count++;
                    end
                    if (m_tdata[OUT_MRK_LO +: HDL_W] != e.marker) begin
                        $error("found_marker: expected %0h, got %0h", e.marker,
                               m_tdata[OUT_MRK_LO +: HDL_W]);
                        fail_count++;
                    end
                    if (m_tdata[OUT_ROOT_LO] != e.root) begin
                        $error("found_root: expected %0d, got %0d", e.root,
                               m_tdata[OUT_ROOT_LO]);
                        fail_count++;
                    end
                    if (m_tdata[OUT_OCC_LO +: CNT_W] != e.occupancy) begin
                        $error("occupancy: expected %0d, got %0d", e.occupancy,
                               m_tdata[OUT_OCC_LO +: CNT_W]);
                        fail_count++;
                    end
                    if (m_tdata[OUT_TOT_LO +: TOT_W] != e.total) begin
                        $error("allocated_total: expected %0h, got %0h", e.total,
                               m_tdata[OUT_TOT_LO +: TOT_W]);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

// ----- tb/testbench.sv -----
// Stimulus and verdict for the Robin Hood pointer table core.
`timescale 1ns / 1ps

module testbench;
    import rhpt_pkg::*;

    localparam int          CYCLE_LIMIT = 4000000;
    localparam logic [2:0]  KIND_SPARE5 = 3'd5;
    localparam logic [2:0]  KIND_SPARE6 = 3'd6;
    localparam logic [2:0]  KIND_SPARE7 = 3'd7;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;
    int                fail_count;
    int                pending;

    int                send_idle_pct;
    int                recv_stall_pct;
    bit                recv_hold;
    int                words_sent;
    logic [KEY_W-1:0]  key_pool [64];

    robin_hood_pointer_table_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    rhpt_scoreboard u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Receiver: random stalls, plus one long hold-off that backs the block up.
    always @(posedge aclk) begin
        m_tready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        recv_hold = 1'b0;
        wait (words_sent == 120);
        recv_hold = 1'b1;
        repeat (400) @(posedge aclk);
        recv_hold = 1'b0;
    end

    // Cycle limit.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("tb: failure");
        $finish;
    end

    function automatic logic [KEY_W-1:0] random_key();
        return KEY_W'({$urandom(), $urandom()});
    endfunction

    // Pool keys crowd a few homes, some at the top of the table so that chains wrap.
    function automatic logic [KEY_W-1:0] crowded_key();
        logic [KEY_W-1:0] k;
        int unsigned h;
        k = random_key();
        h = ($urandom_range(1) == 0) ? $urandom_range(15) : $urandom_range(SLOTS - 1, SLOTS - 6);
        k[HASH_SHIFT +: IDX_W] = h[IDX_W-1:0];
        return k;
    endfunction

    // Offer one word, with a random gap first, and wait for it to be taken.
    task automatic send_word(input logic [KIND_W-1:0] op, input logic [KEY_W-1:0] k,
                             input logic [SIZE_W-1:0] sz, input logic [HDL_W-1:0] dt,
                             input logic [HDL_W-1:0] mk);
        logic [IN_W-1:0] w;
        w = '0;
        w[IN_KIND_LO +: KIND_W] = op;
        w[IN_KEY_LO +: KEY_W]   = k;
        w[IN_SIZE_LO +: SIZE_W] = sz;
        w[IN_DTOR_LO +: HDL_W]  = dt;
        w[IN_MRK_LO +: HDL_W]   = mk;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
    endtask

    task automatic send_random(input logic [KEY_W-1:0] k);
        int pick;
        logic [KIND_W-1:0] op;
        pick = $urandom_range(99);
        if (pick < 35)      op = KIND_INSERT;
        else if (pick < 55) op = KIND_LOOKUP;
        else if (pick < 75) op = KIND_REMOVE;
        else if (pick < 86) op = KIND_UPDATE;
        else if (pick < 96) op = KIND_ROOT;
        else                op = 3'($urandom_range(KIND_SPARE7, KIND_SPARE5));
        send_word(op, k, $urandom(), {$urandom(), $urandom()}, {$urandom(), $urandom()});
    endtask

    initial begin
        logic [KEY_W-1:0] k0, k1, k2, kmax;
        logic [HDL_W-1:0] ones;
        s_tvalid = 1'b0;
        s_tdata = '0;
        aresetn = 1'b0;
        words_sent = 0;
        send_idle_pct = 13;
        recv_stall_pct = 52;
        for (int i = 0; i < 64; i++)
            key_pool[i] = crowded_key();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: field extremes, every kind, duplicates, misses and a displacement.
        ones = '1;
        kmax = '1;
        k0 = '0;
        k1 = 48'h8;
        k2 = 48'h2008;
        send_word(KIND_INSERT, k0, '0, '0, '0);
        send_word(KIND_INSERT, kmax, '1, ones, ones);
        send_word(KIND_INSERT, k0, 32'h1234, ones, ones);
        send_word(KIND_LOOKUP, kmax, '0, '0, '0);
        send_word(KIND_UPDATE, kmax, 32'h5555_aaaa, 64'h0123_4567_89ab_cdef, ones);
        send_word(KIND_ROOT, kmax, '0, '0, '0);
        send_word(KIND_LOOKUP, kmax, '0, '0, '0);
        send_word(KIND_INSERT, kmax, '0, '0, '0);
        send_word(KIND_INSERT, k1, 32'd100, 64'd1, 64'd2);
        send_word(KIND_INSERT, k2, 32'd200, 64'd3, 64'd4);
        send_word(KIND_LOOKUP, k2, '0, '0, '0);
        send_word(KIND_REMOVE, k1, '0, '0, '0);
        send_word(KIND_LOOKUP, k2, '0, '0, '0);
        send_word(KIND_REMOVE, kmax, '0, '0, '0);
        send_word(KIND_REMOVE, kmax, '0, '0, '0);
        send_word(KIND_LOOKUP, kmax, '0, '0, '0);
        send_word(KIND_UPDATE, k1, 32'd7, 64'd7, 64'd7);
        send_word(KIND_ROOT, k1, '0, '0, '0);
        send_word(KIND_SPARE5, k0, '0, '0, '0);
        send_word(KIND_SPARE6, k2, '1, ones, ones);
        send_word(KIND_SPARE7, kmax, '1, ones, ones);

        // Random traffic over crowded keys, with the idling pattern changing as it goes.
        for (int n = 0; n < 665; n++) begin
            if (n == 222) begin
                send_idle_pct = 52;
                recv_stall_pct = 13;
            end else if (n == 444) begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            send_random(($urandom_range(9) == 0) ? random_key() : key_pool[$urandom_range(63)]);
        end

        // Drain the crowded keys.
        for (int i = 0; i < 64; i++)
            send_word(KIND_REMOVE, key_pool[i], '0, '0, '0);
        s_tvalid <= 1'b0;

        wait (pending == 0);
        repeat (50) @(posedge aclk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/rhpt_pkg.sv
rtl/rhpt_datapath.sv
rtl/rhpt_ctrl.sv
rtl/robin_hood_pointer_table_core.sv
rtl/rhpt_checker.sv
tb/rhpt_checker.sv
tb/testbench.sv
